>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SAC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sac_pkg.sv
// Shared constants and codes for the swept-area chain test.
package sac_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_BITS = 16;
  localparam logic [CFG_BITS-1:0] MIN_EXTENT_RESET = 16'd64;

  localparam int CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_PAIR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_POINT = 2'd2;

  // Work codes handed from the front end to the back end.
  localparam int OP_BITS = 3;
  localparam logic [OP_BITS-1:0] OP_PAIR_SMALL = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PAIR_TOUCH = 3'd1;
  localparam logic [OP_BITS-1:0] OP_PAIR_BUILD = 3'd2;
  localparam logic [OP_BITS-1:0] OP_START      = 3'd3;
  localparam logic [OP_BITS-1:0] OP_POINT      = 3'd4;

  localparam logic [1:0] STATUS_TEST  = 2'd0;
  localparam logic [1:0] STATUS_SMALL = 2'd1;
  localparam logic [1:0] STATUS_TOUCH = 2'd2;

  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_CHAIN = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_LINES = 4;

endpackage

>>> hw/rtl/sac_ifs.sv
// Channel interfaces: input items, results and the configuration write.
interface sac_item_if #(parameter int COORD_BITS = sac_pkg::COORD_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic [sac_pkg::CMD_BITS-1:0]  cmd;
  logic signed [COORD_BITS-1:0]  box_a_xl;
  logic signed [COORD_BITS-1:0]  box_a_xh;
  logic signed [COORD_BITS-1:0]  box_a_yl;
  logic signed [COORD_BITS-1:0]  box_a_yh;
  logic signed [COORD_BITS-1:0]  box_b_xl;
  logic signed [COORD_BITS-1:0]  box_b_xh;
  logic signed [COORD_BITS-1:0]  box_b_yl;
  logic signed [COORD_BITS-1:0]  box_b_yh;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic                          last_point;

  modport source (
    output valid, cmd, box_a_xl, box_a_xh, box_a_yl, box_a_yh,
           box_b_xl, box_b_xh, box_b_yl, box_b_yh, point_x, point_y, last_point,
    input  ready
  );
  modport sink (
    input  valid, cmd, box_a_xl, box_a_xh, box_a_yl, box_a_yh,
           box_b_xl, box_b_xh, box_b_yl, box_b_yh, point_x, point_y, last_point,
    output ready
  );
endinterface

interface sac_result_if ();
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] pair_status;
  logic       chain_blocks;

  modport source (output valid, result_kind, pair_status, chain_blocks, input ready);
  modport sink (input valid, result_kind, pair_status, chain_blocks, output ready);
endinterface

interface sac_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [sac_pkg::CFG_BITS-1:0]  min_extent;

  modport source (output valid, min_extent, input ready);
  modport sink (input valid, min_extent, output ready);
endinterface

>>> hw/rtl/sac_front.sv
// Front end: takes items, checks box sizes and touching, finds line corners.
module sac_front #(
  parameter int COORD_BITS = sac_pkg::COORD_BITS_DEF,
  localparam int ENTRY_W = 12 * COORD_BITS + sac_pkg::OP_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  sac_item_if.sink           item,
  sac_cfg_if.sink            cfg,
  output logic               push,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);
  import sac_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + CFG_BITS + 2;

  // wall order: north, east, south, west
  localparam logic [1:0] WALL_N = 2'd0;
  localparam logic [1:0] WALL_E = 2'd1;
  localparam logic [1:0] WALL_S = 2'd2;
  localparam logic [1:0] WALL_W = 2'd3;

  typedef logic [CW-1:0] coord_t;
  typedef logic signed [CW-1:0] scoord_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               last;
    coord_t [3:0]       box;
    coord_t [3:0]       cx;
    coord_t [3:0]       cy;
  } entry_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } corners_t;

  logic [CFG_BITS-1:0] min_extent;
  logic                is_small;
  logic                touch;
  corners_t            ca;
  corners_t            cb;
  entry_t              ent;

  // Entering corner (x0,y0) and leaving corner (x1,y1) of the walls that
  // face away from the other box, walking the corners clockwise from NW.
  function automatic corners_t find_corners(
    scoord_t me_xl, scoord_t me_xh, scoord_t me_yl, scoord_t me_yh,
    scoord_t ot_xl, scoord_t ot_xh, scoord_t ot_yl, scoord_t ot_yh
  );
    logic [3:0] walls;
    corners_t   c;
    logic [1:0] cur;
    logic [1:0] prv;
    scoord_t    x;
    scoord_t    y;
    walls[WALL_W] = me_xl <= ot_xl;
    walls[WALL_E] = me_xh >= ot_xh;
    walls[WALL_S] = me_yl <= ot_yl;
    walls[WALL_N] = me_yh >= ot_yh;
    c = '0;
    for (int s = 0; s < 5; s++) begin
      cur = 2'(s);
      prv = 2'(s + 3);
      x = (cur == WALL_N || cur == WALL_W) ? me_xl : me_xh;
      y = (cur == WALL_N || cur == WALL_E) ? me_yh : me_yl;
      if (!walls[prv] && walls[cur]) begin
        c.x0 = x;
        c.y0 = y;
      end
      if (walls[prv] && !walls[cur]) begin
        c.x1 = x;
        c.y1 = y;
      end
    end
    return c;
  endfunction

  function automatic logic too_small(scoord_t lo, scoord_t hi, logic [CFG_BITS-1:0] lim);
    logic signed [CW:0] ext;
    ext = (CW + 1)'(hi) - (CW + 1)'(lo);
    return $signed(EW'(ext)) < $signed({{(EW - CFG_BITS){1'b0}}, lim});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      min_extent <= MIN_EXTENT_RESET;
    end else if (cfg.valid) begin
      min_extent <= cfg.min_extent;
    end
  end

  assign cfg.ready = 1'b1;
  assign item.ready = push_ready;

  // command 3 is taken and dropped
  assign push = item.valid && push_ready &&
                (item.cmd inside {CMD_PAIR, CMD_START, CMD_POINT});

  always_comb begin
    is_small = too_small(item.box_a_xl, item.box_a_xh, min_extent) ||
               too_small(item.box_a_yl, item.box_a_yh, min_extent) ||
               too_small(item.box_b_xl, item.box_b_xh, min_extent) ||
               too_small(item.box_b_yl, item.box_b_yh, min_extent);
    touch = item.box_b_xl <= item.box_a_xh && item.box_b_xh >= item.box_a_xl &&
            item.box_b_yl <= item.box_a_yh && item.box_b_yh >= item.box_a_yl;
    ca = find_corners(item.box_a_xl, item.box_a_xh, item.box_a_yl, item.box_a_yh,
                      item.box_b_xl, item.box_b_xh, item.box_b_yl, item.box_b_yh);
    cb = find_corners(item.box_b_xl, item.box_b_xh, item.box_b_yl, item.box_b_yh,
                      item.box_a_xl, item.box_a_xh, item.box_a_yl, item.box_a_yh);

    ent.last = item.last_point;
    ent.box[0] = item.box_a_xl;
    ent.box[1] = item.box_a_xh;
    ent.box[2] = item.box_a_yl;
    ent.box[3] = item.box_a_yh;
    // point beats carry the point in every lane
    for (int i = 0; i < 4; i++) begin
      ent.cx[i] = item.point_x;
      ent.cy[i] = item.point_y;
    end

    case (item.cmd)
      CMD_PAIR: begin
        ent.op = is_small ? OP_PAIR_SMALL : (touch ? OP_PAIR_TOUCH : OP_PAIR_BUILD);
        // swept box
        ent.box[0] = (item.box_a_xl < item.box_b_xl) ? item.box_a_xl : item.box_b_xl;
        ent.box[1] = (item.box_a_xh > item.box_b_xh) ? item.box_a_xh : item.box_b_xh;
        ent.box[2] = (item.box_a_yl < item.box_b_yl) ? item.box_a_yl : item.box_b_yl;
        ent.box[3] = (item.box_a_yh > item.box_b_yh) ? item.box_a_yh : item.box_b_yh;
        ent.cx[0] = ca.x0;
        ent.cy[0] = ca.y0;
        ent.cx[1] = ca.x1;
        ent.cy[1] = ca.y1;
        ent.cx[2] = cb.x0;
        ent.cy[2] = cb.y0;
        ent.cx[3] = cb.x1;
        ent.cy[3] = cb.y1;
      end
      CMD_START: ent.op = OP_START;
      default:   ent.op = OP_POINT;
    endcase
  end

  assign push_data = ent;

endmodule

>>> hw/rtl/sac_queue.sv
// Short FIFO between the front end and the back end.
module sac_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sac_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             head_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNTW'(DEPTH);
  assign head_valid = count != '0;
  assign head_data = slots[rd_ptr];
  assign do_push = push && push_ready;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/sac_back.sv
// Back end: line store, side-test pipeline, chain side tracker, result register.
module sac_back #(
  parameter int COORD_BITS = sac_pkg::COORD_BITS_DEF,
  localparam int ENTRY_W = 12 * COORD_BITS + sac_pkg::OP_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  logic [ENTRY_W-1:0] head_data,
  output logic               pop,
  sac_result_if.source       result
);
  import sac_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_ONE  = 2'd1;
  localparam logic [1:0] SIDE_TWO  = 2'd2;

  // corner index = box * 2 + (0 entering, 1 leaving)
  localparam logic [1:0] LINE_FROM [NUM_LINES] = '{2'd0, 2'd2, 2'd0, 2'd1};
  localparam logic [1:0] LINE_TO   [NUM_LINES] = '{2'd1, 2'd3, 2'd3, 2'd2};
  // corner that must fall inside each line's area
  localparam logic [1:0] PROBE_SEL [NUM_LINES] = '{2'd2, 2'd0, 2'd1, 2'd0};

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               last;
    coord_t [3:0]       box;
    coord_t [3:0]       cx;
    coord_t [3:0]       cy;
  } entry_t;

  entry_t head;

  logic signed [CW-1:0] line_ox [NUM_LINES];
  logic signed [CW-1:0] line_oy [NUM_LINES];
  logic signed [DW-1:0] line_dx [NUM_LINES];
  logic signed [DW-1:0] line_dy [NUM_LINES];
  logic [NUM_LINES-1:0] outside;
  logic signed [CW-1:0] swept [4];
  logic                 reach;
  logic                 crossed;
  logic [1:0]           start_side;

  logic                 build_pend;
  coord_t [3:0]         corner_x;
  coord_t [3:0]         corner_y;

  logic                 s1_valid;
  logic [OP_BITS-1:0]   s1_op;
  logic                 s1_last;
  logic                 s1_reach;
  logic signed [DW-1:0] s1_ddx [NUM_LINES];
  logic signed [DW-1:0] s1_ddy [NUM_LINES];

  logic                 s2_valid;
  logic [OP_BITS-1:0]   s2_op;
  logic                 s2_last;
  logic                 s2_reach;
  logic signed [PW-1:0] s2_pl [NUM_LINES];
  logic signed [PW-1:0] s2_pr [NUM_LINES];
  logic [NUM_LINES-1:0] s2_deg;
  logic [NUM_LINES-1:0] s2_sd;

  logic                 out_valid;
  logic                 out_kind;
  logic [1:0]           out_status;
  logic                 out_blocks;

  logic                 adv;
  logic                 inject;
  logic                 new_build;
  logic                 s1_valid_next;
  logic [OP_BITS-1:0]   s1_op_next;
  logic                 reach_next;
  coord_t [3:0]         lane_x;
  coord_t [3:0]         lane_y;
  logic [NUM_LINES-1:0] side;
  logic [NUM_LINES-1:0] deg_next;
  logic [NUM_LINES-1:0] sd_next;
  logic                 hit_end;
  logic [1:0]           code;
  logic [1:0]           start_side_next;
  logic                 crossed_next;
  logic                 has_result;

  assign head = entry_t'(head_data);

  // the whole back end moves only when the result register can take a beat
  assign adv = !out_valid || result.ready;
  assign pop = adv && head_valid && !build_pend;
  assign inject = adv && build_pend;
  assign new_build = pop && head.op == OP_PAIR_BUILD;

  // stage 1 input: queue head, or the outside-side probe of a fresh pair
  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      lane_x[i] = inject ? corner_x[PROBE_SEL[i]] : head.cx[i];
      lane_y[i] = inject ? corner_y[PROBE_SEL[i]] : head.cy[i];
    end
    s1_valid_next = inject || (pop && head.op != OP_PAIR_BUILD);
    s1_op_next = inject ? OP_PAIR_BUILD : head.op;
    reach_next = !(swept[0] > $signed(head.box[1]) || swept[1] < $signed(head.box[0]) ||
                   swept[2] > $signed(head.box[3]) || swept[3] < $signed(head.box[2]));
  end

  // stage 2: axis-aligned lines decide on one coordinate
  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      deg_next[i] = line_dx[i] == '0 || line_dy[i] == '0;
      if (line_dx[i] == '0) begin
        sd_next[i] = s1_ddx[i][DW-1] ? (!line_dy[i][DW-1] && line_dy[i] != '0)
                                     : line_dy[i][DW-1];
      end else begin
        sd_next[i] = s1_ddy[i][DW-1] ? line_dx[i][DW-1]
                                     : (!line_dx[i][DW-1] && line_dx[i] != '0);
      end
    end
  end

  // stage 3: sides, chain tracker
  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      side[i] = s2_deg[i] ? s2_sd[i] : !(s2_pl[i] < s2_pr[i]);
    end
    hit_end = (side[0] == outside[0]) || (side[1] == outside[1]);
    if (side[2] == outside[2]) begin
      code = SIDE_ONE;
    end else if (side[3] == outside[3]) begin
      code = SIDE_TWO;
    end else begin
      code = SIDE_NONE;
    end
    start_side_next = start_side;
    crossed_next = crossed;
    if (reach && !crossed) begin
      if (hit_end) begin
        start_side_next = SIDE_NONE;
      end else if (code != SIDE_NONE) begin
        if (start_side == SIDE_NONE || start_side == code) begin
          start_side_next = code;
        end else begin
          crossed_next = 1'b1;
        end
      end
    end
    has_result = s2_valid && (s2_op != OP_START) && (s2_op != OP_POINT || s2_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_ox[i] <= '0;
        line_oy[i] <= '0;
        line_dx[i] <= '0;
        line_dy[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        swept[i] <= '0;
      end
      outside <= '0;
      reach <= 1'b0;
      crossed <= 1'b0;
      start_side <= SIDE_NONE;
      build_pend <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (new_build) begin
        for (int i = 0; i < NUM_LINES; i++) begin
          line_ox[i] <= $signed(head.cx[LINE_FROM[i]]);
          line_oy[i] <= $signed(head.cy[LINE_FROM[i]]);
          line_dx[i] <= DW'($signed(head.cx[LINE_TO[i]])) -
                        DW'($signed(head.cx[LINE_FROM[i]]));
          line_dy[i] <= DW'($signed(head.cy[LINE_TO[i]])) -
                        DW'($signed(head.cy[LINE_FROM[i]]));
        end
        for (int i = 0; i < 4; i++) begin
          swept[i] <= $signed(head.box[i]);
        end
      end
      build_pend <= new_build;
      s1_valid <= s1_valid_next;
      s2_valid <= s1_valid;
      out_valid <= has_result;
      if (s2_valid) begin
        case (s2_op)
          OP_PAIR_BUILD: outside <= ~side;
          OP_START: begin
            reach <= s2_reach;
            start_side <= SIDE_NONE;
            crossed <= 1'b0;
          end
          OP_POINT: begin
            start_side <= s2_last ? SIDE_NONE : start_side_next;
            crossed <= s2_last ? 1'b0 : crossed_next;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (new_build) begin
        corner_x <= head.cx;
        corner_y <= head.cy;
      end
      s1_op <= s1_op_next;
      s1_last <= head.last;
      s1_reach <= reach_next;
      for (int i = 0; i < NUM_LINES; i++) begin
        s1_ddx[i] <= DW'($signed(lane_x[i])) - DW'(line_ox[i]);
        s1_ddy[i] <= DW'($signed(lane_y[i])) - DW'(line_oy[i]);
      end
      s2_op <= s1_op;
      s2_last <= s1_last;
      s2_reach <= s1_reach;
      for (int i = 0; i < NUM_LINES; i++) begin
        s2_pl[i] <= s1_ddy[i] * line_dx[i];
        s2_pr[i] <= line_dy[i] * s1_ddx[i];
      end
      s2_deg <= deg_next;
      s2_sd <= sd_next;
      out_kind <= (s2_op == OP_POINT) ? KIND_CHAIN : KIND_PAIR;
      out_blocks <= (s2_op == OP_POINT) && reach && crossed_next;
      case (s2_op)
        OP_PAIR_SMALL: out_status <= STATUS_SMALL;
        OP_PAIR_TOUCH: out_status <= STATUS_TOUCH;
        default:       out_status <= STATUS_TEST;
      endcase
    end
  end

  assign result.valid = out_valid;
  assign result.result_kind = out_kind;
  assign result.pair_status = out_status;
  assign result.chain_blocks = out_blocks;

endmodule

>>> hw/rtl/swept_area_chain_block_test.sv
// Top level of the swept-area chain blocking test.
//
//   channel  dir  beat carries
//   item     in   cmd, box a, box b, point, last_point
//   cfg      in   min_extent
//   result   out  result_kind, pair_status, chain_blocks
//
// Chain starts, chain points and rejected pairs enter one per cycle while no
// result is held; a pair that builds lines holds the back end for the line write,
// then the outside probe through the side-test pipeline. Results pass the queue,
// stage 1, stage 2 and the result register, a line-building pair also the build slot.
// rst is synchronous: queue and pipeline empty, lines zero, min_extent 64.
// A held result stalls the back end; the four-entry queue takes beats until full.
module swept_area_chain_block_test #(
  parameter int COORD_BITS = sac_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sac_item_if.sink     item,
  sac_cfg_if.sink      cfg,
  sac_result_if.source result
);
  import sac_pkg::*;

  localparam int ENTRY_W = 12 * COORD_BITS + OP_BITS + 1;

  logic               push;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               head_valid;
  logic [ENTRY_W-1:0] head_data;
  logic               pop;

  sac_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sac_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  sac_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .result     (result)
  );

endmodule

>>> hw/rtl/sac_checker.sv
// Port-level checks for the swept-area chain test, bound to the top level.
`include "assert_macros.svh"

module sac_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic [sac_pkg::CMD_BITS-1:0] item_cmd,
  input logic                         item_last,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic                         result_kind,
  input logic [1:0]                   pair_status,
  input logic                         chain_blocks
);
  import sac_pkg::*;

  // queue, line-build slot, two stages and the result register
  localparam int PEND_MAX = QUEUE_DEPTH + 4;
  localparam int PW = $clog2(PEND_MAX + 2);

  logic [PW-1:0] pending;
  logic          inc;
  logic          dec;

  assign inc = item_valid && item_ready &&
               (item_cmd == CMD_PAIR || (item_cmd == CMD_POINT && item_last));
  assign dec = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (inc && !dec) begin
      pending <= pending + 1'b1;
    end else if (!inc && dec) begin
      pending <= pending - 1'b1;
    end
  end

  `SAC_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable({result_kind, pair_status, chain_blocks}), "result beat changed while stalled")
  `SAC_ASSERT(a_no_extra_result, clk, rst, result_valid |-> pending != '0, "result with no item that owes one")
  `SAC_ASSERT(a_pending_bound, clk, rst, pending <= PW'(PEND_MAX), "more results owed than the block can hold")
  `SAC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !result_valid, "result valid right after reset")

endmodule

bind swept_area_chain_block_test sac_checker u_sac_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_cmd     (item.cmd),
  .item_last    (item.last_point),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_kind  (result.result_kind),
  .pair_status  (result.pair_status),
  .chain_blocks (result.chain_blocks)
);

>>> bench/swept_area_chain_block_test_tb.sv
// Randomized self-checking bench for the swept-area chain blocking test.
`timescale 1ns / 100ps

module swept_area_chain_block_test_tb;
  import sac_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;  // unused code, block ignores it
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_A    = 2'd1;
  localparam logic [1:0] SIDE_B    = 2'd2;
  localparam int SETTLE_CYCLES = 20;
  localparam int CHOKE_CYCLES = 200;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [3:0][CB-1:0] a;  // xl, xh, yl, yh from index 0 up
    logic [3:0][CB-1:0] b;
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic last;
  } sweep_item_t;

  typedef struct packed {
    logic kind;
    logic [1:0] status;
    logic blocks;
  } sweep_outcome_t;

  // Tracks lines, swept box and chain state; queues outcomes owed by pairs and last points.
  class sweep_tracker;
    longint min_extent;
    longint org_x[4], org_y[4], dlt_x[4], dlt_y[4];
    bit out_side[4];
    longint sweep[4];
    bit in_reach;
    bit crossed;
    logic [1:0] first_side;
    sweep_outcome_t pending_outcomes[$];
    int errors;
    int status_seen[3];
    int verdict_seen[2];

    function new();
      min_extent = MIN_EXTENT_RESET;
      for (int i = 0; i < 4; i++) begin
        org_x[i] = 0; org_y[i] = 0; dlt_x[i] = 0; dlt_y[i] = 0;
        out_side[i] = 1'b0;
        sweep[i] = 0;
      end
      in_reach = 1'b0;
      crossed = 1'b0;
      first_side = SIDE_NONE;
      errors = 0;
      status_seen = '{0, 0, 0};
      verdict_seen = '{0, 0};
    endfunction

    function bit side(longint px, longint py, int ln);
      if (dlt_x[ln] == 0) return (px < org_x[ln]) ? (dlt_y[ln] > 0) : (dlt_y[ln] < 0);
      if (dlt_y[ln] == 0) return (py < org_y[ln]) ? (dlt_x[ln] < 0) : (dlt_x[ln] > 0);
      // on the line counts as side 1
      return ((py - org_y[ln]) * dlt_x[ln] < dlt_y[ln] * (px - org_x[ln])) ? 1'b0 : 1'b1;
    endfunction

    function void set_line(int ln, longint x0, longint y0, longint x1, longint y1);
      org_x[ln] = x0;
      org_y[ln] = y0;
      dlt_x[ln] = x1 - x0;
      dlt_y[ln] = y1 - y0;
    endfunction

    function void build_lines(longint bx[2][4]);
      longint cx[2][2], cy[2][2];
      bit wall[4];
      int cur, prv;
      longint x, y;
      for (int bn = 0; bn < 2; bn++) begin
        // walls: north, east, south, west
        wall[3] = bx[bn][0] <= bx[1-bn][0];
        wall[1] = bx[bn][1] >= bx[1-bn][1];
        wall[2] = bx[bn][2] <= bx[1-bn][2];
        wall[0] = bx[bn][3] >= bx[1-bn][3];
        cx[bn][0] = 0; cy[bn][0] = 0; cx[bn][1] = 0; cy[bn][1] = 0;
        for (int s = 0; s < 5; s++) begin
          cur = s % 4;
          prv = (s + 3) % 4;
          x = (cur == 0 || cur == 3) ? bx[bn][0] : bx[bn][1];
          y = (cur == 0 || cur == 1) ? bx[bn][3] : bx[bn][2];
          if (!wall[prv] && wall[cur]) begin
            cx[bn][0] = x; cy[bn][0] = y;
          end
          if (wall[prv] && !wall[cur]) begin
            cx[bn][1] = x; cy[bn][1] = y;
          end
        end
        set_line(bn, cx[bn][0], cy[bn][0], cx[bn][1], cy[bn][1]);
      end
      set_line(2, cx[0][0], cy[0][0], cx[1][1], cy[1][1]);
      set_line(3, cx[0][1], cy[0][1], cx[1][0], cy[1][0]);
      out_side[0] = !side(cx[1][0], cy[1][0], 0);
      out_side[1] = !side(cx[0][0], cy[0][0], 1);
      out_side[2] = !side(cx[0][1], cy[0][1], 2);
      out_side[3] = !side(cx[0][0], cy[0][0], 3);
    endfunction

    function void take_item(sweep_item_t it);
      longint bx[2][4];
      longint px, py;
      logic [1:0] st;
      logic [1:0] sc;
      case (it.cmd)
        CMD_PAIR: begin
          for (int i = 0; i < 4; i++) begin
            bx[0][i] = longint'($signed(it.a[i]));
            bx[1][i] = longint'($signed(it.b[i]));
          end
          if (bx[0][1] - bx[0][0] < min_extent || bx[0][3] - bx[0][2] < min_extent ||
              bx[1][1] - bx[1][0] < min_extent || bx[1][3] - bx[1][2] < min_extent) begin
            st = STATUS_SMALL;
          end else if (bx[1][0] <= bx[0][1] && bx[1][1] >= bx[0][0] &&
                       bx[1][2] <= bx[0][3] && bx[1][3] >= bx[0][2]) begin
            st = STATUS_TOUCH;
          end else begin
            st = STATUS_TEST;
            sweep[0] = (bx[0][0] < bx[1][0]) ? bx[0][0] : bx[1][0];
            sweep[1] = (bx[0][1] > bx[1][1]) ? bx[0][1] : bx[1][1];
            sweep[2] = (bx[0][2] < bx[1][2]) ? bx[0][2] : bx[1][2];
            sweep[3] = (bx[0][3] > bx[1][3]) ? bx[0][3] : bx[1][3];
            build_lines(bx);
          end
          pending_outcomes.push_back('{kind: KIND_PAIR, status: st, blocks: 1'b0});
        end
        CMD_START: begin
          in_reach = !(sweep[0] > longint'($signed(it.a[1])) ||
                       sweep[1] < longint'($signed(it.a[0])) ||
                       sweep[2] > longint'($signed(it.a[3])) ||
                       sweep[3] < longint'($signed(it.a[2])));
          first_side = SIDE_NONE;
          crossed = 1'b0;
        end
        CMD_POINT: begin
          px = longint'($signed(it.px));
          py = longint'($signed(it.py));
          if (in_reach && !crossed) begin
            if (side(px, py, 0) == out_side[0] || side(px, py, 1) == out_side[1]) begin
              first_side = SIDE_NONE;
            end else begin
              sc = SIDE_NONE;
              if (side(px, py, 2) == out_side[2]) sc = SIDE_A;
              else if (side(px, py, 3) == out_side[3]) sc = SIDE_B;
              if (sc != SIDE_NONE) begin
                if (first_side == SIDE_NONE || first_side == sc) first_side = sc;
                else crossed = 1'b1;
              end
            end
          end
          if (it.last) begin
            pending_outcomes.push_back('{kind: KIND_CHAIN, status: STATUS_TEST,
                                         blocks: in_reach && crossed});
            first_side = SIDE_NONE;
            crossed = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void match_outcome(sweep_outcome_t got);
      sweep_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected: kind %0d status %0d blocks %0d",
               got.kind, got.status, got.blocks);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (want.kind === KIND_PAIR) status_seen[want.status]++;
      else verdict_seen[want.blocks]++;
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("pair_status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.blocks !== want.blocks) begin
        $error("chain_blocks: expected %0d, got %0d", want.blocks, got.blocks);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit calm;
  bit choke_req;
  int items_offered;
  int settings_used;
  sweep_tracker board;
  sweep_item_t beat_in;

  sac_item_if #(.COORD_BITS(CB)) item_ch ();
  sac_cfg_if cfg_ch ();
  sac_result_if res_ch ();

  swept_area_chain_block_test #(.COORD_BITS(CB)) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .cfg(cfg_ch),
    .result(res_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      board.match_outcome('{kind: res_ch.result_kind, status: res_ch.pair_status,
                            blocks: res_ch.chain_blocks});
    end
    if (!rst && item_ch.valid && item_ch.ready) begin
      beat_in.cmd = item_ch.cmd;
      beat_in.a = {item_ch.box_a_yh, item_ch.box_a_yl, item_ch.box_a_xh, item_ch.box_a_xl};
      beat_in.b = {item_ch.box_b_yh, item_ch.box_b_yl, item_ch.box_b_xh, item_ch.box_b_xl};
      beat_in.px = item_ch.point_x;
      beat_in.py = item_ch.point_y;
      beat_in.last = item_ch.last_point;
      board.take_item(beat_in);
    end
  end

  // Result sink: random back-pressure, plus one long hold-off on request.
  initial begin
    int held;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        res_ch.ready <= 1'b0;
        for (held = 0; held < CHOKE_CYCLES; held++) @(negedge clk);
        choke_req = 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  function automatic logic [CB-1:0] clamp_coord(input longint v);
    longint lo, hi;
    lo = -(longint'(1) <<< (CB - 1));
    hi = (longint'(1) <<< (CB - 1)) - 1;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[CB-1:0];
  endfunction

  function automatic longint pick(input longint lo, input longint hi);
    if (hi <= lo) return lo;
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic sweep_item_t mk_pair(input longint axl, axh, ayl, ayh,
                                           input longint bxl, bxh, byl, byh);
    sweep_item_t it;
    it = '0;
    it.cmd = CMD_PAIR;
    it.a = {clamp_coord(ayh), clamp_coord(ayl), clamp_coord(axh), clamp_coord(axl)};
    it.b = {clamp_coord(byh), clamp_coord(byl), clamp_coord(bxh), clamp_coord(bxl)};
    return it;
  endfunction

  function automatic sweep_item_t mk_start(input longint xl, xh, yl, yh);
    sweep_item_t it;
    it = '0;
    it.cmd = CMD_START;
    it.a = {clamp_coord(yh), clamp_coord(yl), clamp_coord(xh), clamp_coord(xl)};
    return it;
  endfunction

  function automatic sweep_item_t mk_point(input longint x, y, input logic last);
    sweep_item_t it;
    it = '0;
    it.cmd = CMD_POINT;
    it.px = clamp_coord(x);
    it.py = clamp_coord(y);
    it.last = last;
    return it;
  endfunction

  function automatic sweep_item_t mk_noise();
    sweep_item_t it;
    it.cmd = CMD_BITS'($urandom_range(0, 3));
    it.a = {$urandom(), $urandom()};
    it.b = {$urandom(), $urandom()};
    it.px = CB'($urandom());
    it.py = CB'($urandom());
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic longint extent_near(input longint me);
    longint s;
    s = me + $urandom_range(0, 3000);
    if (me > 0 && $urandom_range(0, 15) == 0) s = me - 1;  // occasional small sector
    if (s > 65535) s = 65535;
    return s;
  endfunction

  // Two boxes apart in x, in y, or both, sized around the current minimum extent.
  function automatic sweep_item_t gen_pair();
    longint w0, h0, w1, h1, ax, ay, bx, by, gap;
    int mode;
    w0 = extent_near(board.min_extent);
    h0 = extent_near(board.min_extent);
    w1 = extent_near(board.min_extent);
    h1 = extent_near(board.min_extent);
    ax = pick(-25000, 25000);
    ay = pick(-25000, 25000);
    mode = $urandom_range(0, 2);
    gap = pick(1, 5000);
    if (mode == 1) bx = ax + pick(-w0, w0);
    else bx = $urandom_range(0, 1) ? ax + w0 + gap : ax - gap - w1;
    gap = pick(1, 5000);
    if (mode == 0) by = ay + pick(-h0, h0);
    else by = $urandom_range(0, 1) ? ay + h0 + gap : ay - gap - h1;
    return mk_pair(ax, ax + w0, ay, ay + h0, bx, bx + w1, by, by + h1);
  endfunction

  task automatic offer_item(input sweep_item_t it);
    if (!calm && $urandom_range(0, 99) < 16) begin
      item_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 16);
    end
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= it.cmd;
    item_ch.box_a_xl   <= it.a[0];
    item_ch.box_a_xh   <= it.a[1];
    item_ch.box_a_yl   <= it.a[2];
    item_ch.box_a_yh   <= it.a[3];
    item_ch.box_b_xl   <= it.b[0];
    item_ch.box_b_xh   <= it.b[1];
    item_ch.box_b_yl   <= it.b[2];
    item_ch.box_b_yh   <= it.b[3];
    item_ch.point_x    <= it.px;
    item_ch.point_y    <= it.py;
    item_ch.last_point <= it.last;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (it.cmd != CMD_SPARE) items_offered++;
  endtask

  // Chain start then a few points, mostly around the current swept box.
  task automatic run_chain();
    longint mx, my, cx, cy;
    int n;
    mx = (board.sweep[1] - board.sweep[0]) / 4 + 16;
    my = (board.sweep[3] - board.sweep[2]) / 4 + 16;
    if ($urandom_range(0, 6) == 0) begin
      offer_item(mk_start(pick(-32768, 32767), pick(-32768, 32767),
                          pick(-32768, 32767), pick(-32768, 32767)));
    end else begin
      cx = pick(board.sweep[0], board.sweep[1]);
      cy = pick(board.sweep[2], board.sweep[3]);
      offer_item(mk_start(cx - pick(0, 3000), cx + pick(0, 3000),
                          cy - pick(0, 3000), cy + pick(0, 3000)));
    end
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      offer_item(mk_point(pick(board.sweep[0] - mx, board.sweep[1] + mx),
                          pick(board.sweep[2] - my, board.sweep[3] + my), i == n - 1));
    end
  endtask

  task automatic run_random(input int n);
    int goal;
    int r;
    goal = items_offered + n;
    while (items_offered < goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        offer_item(gen_pair());
        repeat ($urandom_range(1, 3)) run_chain();
      end else if (r < 80) begin
        run_chain();
      end else if (r < 88) begin
        repeat ($urandom_range(1, 3)) begin
          offer_item(mk_point(pick(-32768, 32767), pick(-32768, 32767),
                              1'($urandom_range(0, 1))));
        end
      end else begin
        offer_item(mk_noise());
      end
    end
  endtask

  // Wait until every expected beat is back and the pipeline has flushed.
  task automatic settle();
    while (board.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_min_extent(input logic [CFG_BITS-1:0] v);
    cfg_ch.min_extent <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    board.min_extent = v;
    settings_used++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    longint phase_extent[6];
    int phase_items[6];
    board = new();
    rst = 1'b1;
    calm = 1'b0;
    choke_req = 1'b0;
    items_offered = 0;
    settings_used = 1;
    item_ch.valid = 1'b0;
    item_ch.cmd = CMD_PAIR;
    item_ch.box_a_xl = '0; item_ch.box_a_xh = '0;
    item_ch.box_a_yl = '0; item_ch.box_a_yh = '0;
    item_ch.box_b_xl = '0; item_ch.box_b_xh = '0;
    item_ch.box_b_yl = '0; item_ch.box_b_yh = '0;
    item_ch.point_x = '0; item_ch.point_y = '0;
    item_ch.last_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.min_extent = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // chain on reset lines, before any pair
    offer_item(mk_start(-10, 10, -10, 10));
    offer_item(mk_point(5, 5, 1'b0));
    offer_item(mk_point(-5, -5, 1'b1));
    offer_item('{cmd: CMD_SPARE, a: '1, b: '1, px: '1, py: '1, last: 1'b1});
    offer_item(mk_pair(0, 63, 0, 100, 500, 600, 0, 100));         // one side too small
    offer_item(mk_pair(0, 100, 0, 100, 100, 200, 0, 100));        // edges meet
    offer_item(mk_pair(0, 100, 0, 100, 101, 200, 0, 100));        // one apart
    offer_item(mk_pair(-32768, -31768, -32768, 32767, 31767, 32767, -32768, 32767));
    offer_item(mk_start(-32768, 32767, -32768, 32767));
    offer_item(mk_point(-32768, -32768, 1'b0));
    offer_item(mk_point(0, 32767, 1'b0));
    offer_item(mk_point(0, -32768, 1'b0));
    offer_item(mk_point(32767, 32767, 1'b1));
    offer_item(mk_pair(-2000, -1000, -500, 500, 1000, 2000, -500, 500));
    offer_item(mk_start(-100, 100, -1000, 1000));
    offer_item(mk_point(0, 800, 1'b0));
    offer_item(mk_point(0, 0, 1'b0));
    offer_item(mk_point(0, -800, 1'b0));
    offer_item(mk_point(0, 900, 1'b0));                           // after the crossing
    offer_item(mk_point(0, 0, 1'b1));
    offer_item(mk_point(0, -800, 1'b0));                          // new chain, no start
    offer_item(mk_point(0, 800, 1'b1));
    offer_item(mk_start(5000, 6000, 5000, 6000));                 // out of reach
    offer_item(mk_point(0, 800, 1'b0));
    offer_item(mk_point(0, -800, 1'b1));
    offer_item(mk_pair(-3000, -2000, -3000, -2000, 2000, 3000, 2000, 3000));

    phase_extent = '{16, 0, 65535, longint'($urandom_range(1, 300)), 1, 64};
    phase_items  = '{450, 300, 150, 450, 200, 400};
    for (int p = 0; p < 6; p++) begin
      item_ch.valid <= 1'b0;
      settle();
      write_min_extent(phase_extent[p][CFG_BITS-1:0]);
      calm = (p == 3);
      if (p == 0) choke_req = 1'b1;  // sender keeps pushing while results back up
      run_random(phase_items[p]);
    end
    calm = 1'b0;
    item_ch.valid <= 1'b0;
    settle();

    $display("Sent %0d items across %0d min_extent settings; pairs test/small/touch %0d/%0d/%0d",
             items_offered, settings_used, board.status_seen[0], board.status_seen[1],
             board.status_seen[2]);
    $display("Chain verdicts blocked/open %0d/%0d, %0d mismatches",
             board.verdict_seen[1], board.verdict_seen[0], board.errors);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout: results still outstanding");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sac_pkg.sv
hw/rtl/sac_ifs.sv
hw/rtl/sac_front.sv
hw/rtl/sac_queue.sv
hw/rtl/sac_back.sv
hw/rtl/swept_area_chain_block_test.sv
hw/rtl/sac_checker.sv
bench/swept_area_chain_block_test_tb.sv
